// ===== sv/lavg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lavg_pkg
// Shared types and constants for the linear ADSR voice gain unit.
// ----------------------------------------------------------------------------
package lavg_pkg;

    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int LEVEL_W          = 24;
    localparam int VEL_W            = 16;
    localparam int STAGE_W          = 3;
    localparam int OPCODE_W         = 2;
    localparam int CFG_INDEX_W      = 2;
    localparam int QUEUE_DEPTH      = 2;
    localparam int VEL_FRAC         = 15;
    localparam int GAIN_FRAC        = 23;

    localparam logic [LEVEL_W-1:0] ONE_Q23 = 24'd8388608;
    localparam logic [VEL_W-1:0]   ONE_Q15 = 16'd32768;

    // Envelope stage codes.
    localparam logic [STAGE_W-1:0] ST_IDLE    = 3'd0;
    localparam logic [STAGE_W-1:0] ST_ATTACK  = 3'd1;
    localparam logic [STAGE_W-1:0] ST_DECAY   = 3'd2;
    localparam logic [STAGE_W-1:0] ST_SUSTAIN = 3'd3;
    localparam logic [STAGE_W-1:0] ST_RELEASE = 3'd4;

    // Input opcodes.
    localparam logic [OPCODE_W-1:0] OP_TICK     = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_NOTE_ON  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_NOTE_OFF = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_ATTACK  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DECAY   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SUSTAIN = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RELEASE = 2'd3;

    // Envelope state of one tick as handed from the front to the back.
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [VEL_W-1:0]   velocity;
        logic               active;
    } t_tick_ctrl;

endpackage
`default_nettype wire

// ===== sv/lavg_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lavg_front
// Configuration registers, command decode and the envelope recurrence.
// ----------------------------------------------------------------------------
module lavg_front import lavg_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire  [CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire  [LEVEL_W-1:0]       i_cfg_data,
    input  wire                      i_in_valid,
    input  wire  [OPCODE_W-1:0]      i_opcode,
    input  wire  [VEL_W-1:0]         i_note_velocity,
    input  wire  [SAMPLE_WIDTH-1:0]  i_left_in,
    input  wire  [SAMPLE_WIDTH-1:0]  i_right_in,
    input  wire                      i_q_full,
    output logic                     o_push,
    output t_tick_ctrl               o_push_ctrl,
    output logic [SAMPLE_WIDTH-1:0]  o_push_left,
    output logic [SAMPLE_WIDTH-1:0]  o_push_right
);

    logic [LEVEL_W-1:0] r_attack_step;
    logic [LEVEL_W-1:0] r_decay_step;
    logic [LEVEL_W-1:0] r_sustain_level;
    logic [LEVEL_W-1:0] r_release_step;

    logic [STAGE_W-1:0] r_stage, n_stage;
    logic [LEVEL_W-1:0] r_level, n_level;
    logic [VEL_W-1:0]   r_velocity, n_velocity;

    logic               accept;
    logic [LEVEL_W-1:0] sustain_eff;
    logic [LEVEL_W:0]   attack_sum;
    logic [LEVEL_W:0]   decay_floor;

    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && !i_q_full;
    assign sustain_eff = (r_sustain_level > ONE_Q23) ? ONE_Q23 : r_sustain_level;
    assign attack_sum  = {1'b0, r_level} + {1'b0, r_attack_step};
    // Decay ends once level - step <= sustain, that is level <= sustain + step.
    assign decay_floor = {1'b0, sustain_eff} + {1'b0, r_decay_step};

    always_comb begin
        n_stage    = r_stage;
        n_level    = r_level;
        n_velocity = r_velocity;
        if (accept) begin
            case (i_opcode)
                OP_NOTE_ON: begin
                    n_velocity = (i_note_velocity > ONE_Q15) ? ONE_Q15 : i_note_velocity;
                    n_stage    = ST_ATTACK;
                end
                OP_NOTE_OFF: begin
                    if (r_stage != ST_IDLE) begin
                        n_stage = ST_RELEASE;
                    end
                end
                OP_TICK: begin
                    case (r_stage)
                        ST_IDLE: begin
                            n_stage = ST_IDLE;
                        end
                        ST_ATTACK: begin
                            if (attack_sum >= {1'b0, ONE_Q23}) begin
                                n_level = ONE_Q23;
                                n_stage = ST_DECAY;
                            end else begin
                                n_level = attack_sum[LEVEL_W-1:0];
                            end
                        end
                        ST_DECAY: begin
                            if ({1'b0, r_level} <= decay_floor) begin
                                n_level = sustain_eff;
                                n_stage = ST_SUSTAIN;
                            end else begin
                                n_level = r_level - r_decay_step;
                            end
                        end
                        ST_SUSTAIN: begin
                            n_level = sustain_eff;
                        end
                        ST_RELEASE: begin
                            if (r_level <= r_release_step) begin
                                n_level = '0;
                                n_stage = ST_IDLE;
                            end else begin
                                n_level = r_level - r_release_step;
                            end
                        end
                        default: begin
                            n_stage = ST_IDLE;
                        end
                    endcase
                end
                default: begin
                    n_stage = r_stage;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack_step   <= ONE_Q23;
            r_decay_step    <= ONE_Q23;
            r_sustain_level <= ONE_Q23;
            r_release_step  <= ONE_Q23;
            r_stage         <= ST_IDLE;
            r_level         <= '0;
            r_velocity      <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_ATTACK:  r_attack_step   <= i_cfg_data;
                    CFG_DECAY:   r_decay_step    <= i_cfg_data;
                    CFG_SUSTAIN: r_sustain_level <= i_cfg_data;
                    CFG_RELEASE: r_release_step  <= i_cfg_data;
                    default:     r_attack_step   <= r_attack_step;
                endcase
            end
            r_stage    <= n_stage;
            r_level    <= n_level;
            r_velocity <= n_velocity;
        end
    end

    // Only ticks produce a result; the queue carries the post-tick state.
    assign o_push               = accept && (i_opcode == OP_TICK);
    assign o_push_ctrl.level    = n_level;
    assign o_push_ctrl.velocity = r_velocity;
    assign o_push_ctrl.active   = (n_stage != ST_IDLE);
    assign o_push_left          = i_left_in;
    assign o_push_right         = i_right_in;

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= ONE_Q23)
        else $error("envelope level above full scale");

    a_idle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stage == ST_IDLE) |-> (r_level == '0))
        else $error("idle voice holds a nonzero level");

endmodule
`default_nettype wire

// ===== sv/lavg_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lavg_queue
// Short first-in first-out queue between the envelope front and the gain back.
// ----------------------------------------------------------------------------
module lavg_queue import lavg_pkg::*; #(
    parameter int DATA_W = 64
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  wire  [DATA_W-1:0] i_data,
    output logic              o_full,
    input  wire               i_pop,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    logic [DATA_W-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count beyond its depth");

endmodule
`default_nettype wire

// ===== sv/lavg_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lavg_back
// Two-stage gain pipeline: level times velocity, then sample times gain.
// ----------------------------------------------------------------------------
module lavg_back import lavg_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_q_valid,
    input  wire  t_tick_ctrl               i_q_ctrl,
    input  wire  signed [SAMPLE_WIDTH-1:0] i_q_left,
    input  wire  signed [SAMPLE_WIDTH-1:0] i_q_right,
    output logic                           o_q_pop,
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_left_out,
    output logic signed [SAMPLE_WIDTH-1:0] o_right_out,
    output logic        [LEVEL_W-1:0]      o_envelope_level,
    output logic                           o_voice_active
);

    localparam int GPROD_W = LEVEL_W + VEL_W;
    localparam int SPROD_W = SAMPLE_WIDTH + LEVEL_W + 1;

    // Stage one: gain.
    logic                           r_s1_valid;
    logic        [LEVEL_W-1:0]      r_s1_gain;
    logic        [LEVEL_W-1:0]      r_s1_level;
    logic                           r_s1_active;
    logic signed [SAMPLE_WIDTH-1:0] r_s1_left;
    logic signed [SAMPLE_WIDTH-1:0] r_s1_right;
    // Stage two: output register.
    logic                           r_s2_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_s2_left;
    logic signed [SAMPLE_WIDTH-1:0] r_s2_right;
    logic        [LEVEL_W-1:0]      r_s2_level;
    logic                           r_s2_active;

    logic                           s1_load;
    logic                           s2_load;
    logic        [GPROD_W-1:0]      gain_prod;
    logic signed [SPROD_W-1:0]      left_prod;
    logic signed [SPROD_W-1:0]      right_prod;

    assign s2_load = r_s1_valid && (!r_s2_valid || !i_out_stall);
    assign s1_load = i_q_valid && (!r_s1_valid || s2_load);
    assign o_q_pop = s1_load;

    assign gain_prod  = GPROD_W'(i_q_ctrl.level) * GPROD_W'(i_q_ctrl.velocity);
    // Arithmetic shift of the product floors toward minus infinity.
    assign left_prod  = SPROD_W'(r_s1_left) * $signed({1'b0, r_s1_gain});
    assign right_prod = SPROD_W'(r_s1_right) * $signed({1'b0, r_s1_gain});

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_gain   <= gain_prod[VEL_FRAC +: LEVEL_W];
            r_s1_level  <= i_q_ctrl.level;
            r_s1_active <= i_q_ctrl.active;
            r_s1_left   <= i_q_left;
            r_s1_right  <= i_q_right;
        end
        if (s2_load) begin
            r_s2_level  <= r_s1_level;
            r_s2_active <= r_s1_active;
            if (r_s1_active) begin
                r_s2_left  <= left_prod[GAIN_FRAC +: SAMPLE_WIDTH];
                r_s2_right <= right_prod[GAIN_FRAC +: SAMPLE_WIDTH];
            end else begin
                r_s2_left  <= '0;
                r_s2_right <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_load) begin
                r_s1_valid <= 1'b1;
            end else if (s2_load) begin
                r_s1_valid <= 1'b0;
            end
            if (s2_load) begin
                r_s2_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_s2_valid;
    assign o_left_out       = r_s2_left;
    assign o_right_out      = r_s2_right;
    assign o_envelope_level = r_s2_level;
    assign o_voice_active   = r_s2_active;

    a_silent_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !r_s2_active) |-> (r_s2_left == '0 && r_s2_right == '0))
        else $error("inactive voice produced a nonzero sample");

    a_stalled_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && i_out_stall) |=> (r_s2_valid && $stable(r_s2_level)))
        else $error("stalled result was lost or changed");

endmodule
`default_nettype wire

// ===== sv/linear_adsr_voice_gain_unit.sv =====
`default_nettype none
// An accepted sample tick passes through the queue, the gain stage and the output register.
// Throughput: one beat per cycle, ticks and note events alike, while nothing stalls.
// Note on, note off and the unused opcode give no result.
// Reset (synchronous, active low) idles the voice, clears level and velocity,
// empties the queue and pipeline, and sets the three steps and sustain to 1.0.
// ----------------------------------------------------------------------------
// linear_adsr_voice_gain_unit
// Linear ADSR envelope with velocity gain applied to a stereo sample stream.
// ----------------------------------------------------------------------------
module linear_adsr_voice_gain_unit import lavg_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // Configuration write channel.
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire         [CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire         [LEVEL_W-1:0]      i_cfg_data,
    // Input beats.
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  wire         [OPCODE_W-1:0]     i_opcode,
    input  wire         [VEL_W-1:0]        i_note_velocity,
    input  wire  signed [SAMPLE_WIDTH-1:0] i_left_in,
    input  wire  signed [SAMPLE_WIDTH-1:0] i_right_in,
    // Result beats.
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_left_out,
    output logic signed [SAMPLE_WIDTH-1:0] o_right_out,
    output logic        [LEVEL_W-1:0]      o_envelope_level,
    output logic                           o_voice_active
);

    // The queue carries the envelope state of a tick plus both raw samples.
    localparam int CTRL_W = $bits(t_tick_ctrl);
    localparam int Q_W    = CTRL_W + 2 * SAMPLE_WIDTH;

    logic                    push;
    t_tick_ctrl              push_ctrl;
    logic [SAMPLE_WIDTH-1:0] push_left;
    logic [SAMPLE_WIDTH-1:0] push_right;
    logic                    q_full;
    logic                    q_valid;
    logic                    q_pop;
    logic [Q_W-1:0]          q_data;
    t_tick_ctrl              q_ctrl;

    // The front decodes each beat and runs the envelope recurrence in the
    // cycle the beat is accepted, so note events wait on the back only through a full queue.
    // Input stalls only when the queue toward the gain pipeline is full.
    lavg_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_opcode        (i_opcode),
        .i_note_velocity (i_note_velocity),
        .i_left_in       (i_left_in),
        .i_right_in      (i_right_in),
        .i_q_full        (q_full),
        .o_push          (push),
        .o_push_ctrl     (push_ctrl),
        .o_push_left     (push_left),
        .o_push_right    (push_right)
    );

    assign o_in_stall = q_full;

    lavg_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({push_ctrl, push_left, push_right}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign q_ctrl = q_data[Q_W-1 -: CTRL_W];

    // The back forms the gain and scales both channels; its output register
    // lets the gain stage take one more entry from the queue while a finished result waits.
    lavg_back #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_q_ctrl         (q_ctrl),
        .i_q_left         (q_data[SAMPLE_WIDTH +: SAMPLE_WIDTH]),
        .i_q_right        (q_data[SAMPLE_WIDTH-1:0]),
        .o_q_pop          (q_pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_left_out       (o_left_out),
        .o_right_out      (o_right_out),
        .o_envelope_level (o_envelope_level),
        .o_voice_active   (o_voice_active)
    );

endmodule
`default_nettype wire
